// File: hw/rtl/dfsp_pkg.sv
// ----------------------------------------------------------------------------
// dfsp_pkg
// Shared types and constants of the dual-format sensor packet deframer.
// ----------------------------------------------------------------------------
package dfsp_pkg;

   localparam logic [7:0] SYNC_A  = 8'hAA;
   localparam logic [7:0] SYNC_B  = 8'hBB;
   localparam logic [7:0] HDR1_T  = 8'h54;
   localparam logic [7:0] HDR1_E  = 8'h45;
   localparam logic [7:0] HDR2_2  = 8'h32;
   localparam logic [7:0] HDR2_H  = 8'h23;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam int unsigned SENS_BYTES = 6;
   localparam int unsigned DATA_BYTES = 3;

   localparam logic KIND_SENSOR = 1'b0;
   localparam logic KIND_STAMP  = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       packet_kind;
      logic [7:0] payload0;
      logic [7:0] payload1;
      logic [7:0] payload2;
      logic [7:0] payload3;
      logic [7:0] payload4;
      logic [7:0] payload5;
      logic [4:0] stamp_index;
      logic [7:0] stamp_char;
      logic [7:0] packets_done;
      logic       last;
   } rsp_type;

   typedef enum logic [9:0] {
      ST_SYNC1 = 10'b00_0000_0001,
      ST_SYNC2 = 10'b00_0000_0010,
      ST_HDR1  = 10'b00_0000_0100,
      ST_HDR2  = 10'b00_0000_1000,
      ST_SENS  = 10'b00_0001_0000,
      ST_DATA  = 10'b00_0010_0000,
      ST_STAMP = 10'b00_0100_0000,
      ST_CR    = 10'b00_1000_0000,
      ST_LF    = 10'b01_0000_0000,
      ST_DRAIN = 10'b10_0000_0000
   } state_type;

endpackage

// File: hw/rtl/dfsp_chan_if.sv
// ----------------------------------------------------------------------------
// dfsp_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dfsp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/dual_format_sensor_packet_deframer.sv
// ----------------------------------------------------------------------------
// dual_format_sensor_packet_deframer
// Hunts AA BB sync, decodes TE sensor and 2# timestamped packets, checks
// the CR LF trailer and emits one result (TE) or one result per timestamp
// byte (2#) read back from the stamp memory.
//
//   channel   dir   payload          accepted when
//   req_if    in    req_type         req_if.valid & req_if.ready
//   rsp_if    out   rsp_type         rsp_if.valid & rsp_if.ready
//
// One received byte per cycle while parsing, except for the stalls below.
// A 2# packet drains STAMP_LEN results through the single memory read port;
// each read waits for a free output register; no byte is taken during the drain.
// The LF byte waits while the output register still holds a result.
// Synchronous active-high reset returns the parser to the sync hunt;
// the stamp memory is not cleared (every entry is written before it is read).
// ----------------------------------------------------------------------------
module dual_format_sensor_packet_deframer #(
   parameter int unsigned STAMP_LEN = 26
) (
   input  logic         clock,
   input  logic         reset,
   dfsp_chan_if.sink    req_if,
   dfsp_chan_if.source  rsp_if
);

   localparam int unsigned AW = (STAMP_LEN > 1) ? $clog2(STAMP_LEN) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(STAMP_LEN - 1);

   dfsp_pkg::state_type state_ff, state_in;

   logic [7:0]     header_first_ff;
   logic           kind_ff, kind_in;
   logic [7:0]     payload_ff [dfsp_pkg::SENS_BYTES];
   logic [2:0]     field_pos_ff, field_pos_in;
   logic [AW-1:0]  stamp_count_ff, stamp_count_in;
   logic [7:0]     counter_ff, counter_in;

   logic [7:0]     stamp_mem [STAMP_LEN];
   logic [7:0]     rd_data_ff;
   logic [AW-1:0]  rd_idx_ff, rd_idx_in;
   logic           rd_pend_ff, rd_pend_in;
   logic           rd_issue;

   dfsp_pkg::rsp_type rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [7:0]     b;
   logic           req_acc, rsp_acc;
   logic           lf_ok;
   logic [31:0]    rd_idx_wide;

   assign b       = req_if.data.rx_byte;
   assign req_acc = req_if.valid & req_if.ready;
   assign rsp_acc = rsp_if.valid & rsp_if.ready;

   assign req_if.ready = (state_ff != dfsp_pkg::ST_DRAIN) &&
                         !((state_ff == dfsp_pkg::ST_LF) && rsp_valid_ff);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;

   assign lf_ok    = req_acc && (state_ff == dfsp_pkg::ST_LF) && (b == dfsp_pkg::CHAR_LF);
   assign rd_issue = (state_ff == dfsp_pkg::ST_DRAIN) && !rd_pend_ff &&
                     (!rsp_valid_ff || rsp_acc);
   assign rd_idx_wide = 32'(rd_idx_ff);

   // parser and drain sequencer
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      field_pos_in   = field_pos_ff;
      stamp_count_in = stamp_count_ff;
      counter_in     = counter_ff;
      rd_idx_in      = rd_idx_ff;
      rd_pend_in     = rd_issue;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_acc;

      if (req_acc) begin
         case (state_ff)
            dfsp_pkg::ST_SYNC1: begin
               if (b == dfsp_pkg::SYNC_A) state_in = dfsp_pkg::ST_SYNC2;
            end
            dfsp_pkg::ST_SYNC2: begin
               state_in = (b == dfsp_pkg::SYNC_B) ? dfsp_pkg::ST_HDR1 : dfsp_pkg::ST_SYNC1;
            end
            dfsp_pkg::ST_HDR1: begin
               state_in = dfsp_pkg::ST_HDR2;
            end
            dfsp_pkg::ST_HDR2: begin
               field_pos_in = '0;
               if (header_first_ff == dfsp_pkg::HDR1_T && b == dfsp_pkg::HDR1_E) begin
                  kind_in  = dfsp_pkg::KIND_SENSOR;
                  state_in = dfsp_pkg::ST_SENS;
               end else if (header_first_ff == dfsp_pkg::HDR2_2 &&
                            b == dfsp_pkg::HDR2_H) begin
                  kind_in  = dfsp_pkg::KIND_STAMP;
                  state_in = dfsp_pkg::ST_DATA;
               end else begin
                  state_in = dfsp_pkg::ST_SYNC1;
               end
            end
            dfsp_pkg::ST_SENS: begin
               field_pos_in = field_pos_ff + 3'd1;
               if (field_pos_ff == 3'(dfsp_pkg::SENS_BYTES - 1))
                  state_in = dfsp_pkg::ST_CR;
            end
            dfsp_pkg::ST_DATA: begin
               field_pos_in = field_pos_ff + 3'd1;
               if (field_pos_ff == 3'(dfsp_pkg::DATA_BYTES - 1)) begin
                  stamp_count_in = '0;
                  state_in       = dfsp_pkg::ST_STAMP;
               end
            end
            dfsp_pkg::ST_STAMP: begin
               stamp_count_in = stamp_count_ff + AW'(1);
               if (stamp_count_ff == LAST_IDX) state_in = dfsp_pkg::ST_CR;
            end
            dfsp_pkg::ST_CR: begin
               state_in = (b == dfsp_pkg::CHAR_CR) ? dfsp_pkg::ST_LF : dfsp_pkg::ST_SYNC1;
            end
            dfsp_pkg::ST_LF: begin
               state_in = dfsp_pkg::ST_SYNC1;
               if (b == dfsp_pkg::CHAR_LF) begin
                  counter_in = counter_ff + 8'd1;
                  if (kind_ff == dfsp_pkg::KIND_SENSOR) begin
                     rsp_in.packet_kind  = dfsp_pkg::KIND_SENSOR;
                     rsp_in.payload0     = payload_ff[0];
                     rsp_in.payload1     = payload_ff[1];
                     rsp_in.payload2     = payload_ff[2];
                     rsp_in.payload3     = payload_ff[3];
                     rsp_in.payload4     = payload_ff[4];
                     rsp_in.payload5     = payload_ff[5];
                     rsp_in.stamp_index  = '0;
                     rsp_in.stamp_char   = '0;
                     rsp_in.packets_done = counter_ff + 8'd1;
                     rsp_in.last         = 1'b1;
                     rsp_valid_in        = 1'b1;
                  end else begin
                     rd_idx_in = '0;
                     state_in  = dfsp_pkg::ST_DRAIN;
                  end
               end
            end
            default: begin
               state_in = dfsp_pkg::ST_SYNC1;
            end
         endcase
      end

      // memory data lands; the output register is free by construction
      if (rd_pend_ff) begin
         rsp_in.packet_kind  = dfsp_pkg::KIND_STAMP;
         rsp_in.payload0     = payload_ff[0];
         rsp_in.payload1     = payload_ff[1];
         rsp_in.payload2     = payload_ff[2];
         rsp_in.payload3     = '0;
         rsp_in.payload4     = '0;
         rsp_in.payload5     = '0;
         rsp_in.stamp_index  = rd_idx_wide[4:0];
         rsp_in.stamp_char   = (rd_idx_ff == LAST_IDX) ? 8'h00 : rd_data_ff;
         rsp_in.packets_done = counter_ff;
         rsp_in.last         = (rd_idx_ff == LAST_IDX);
         rsp_valid_in        = 1'b1;
         rd_idx_in           = rd_idx_ff + AW'(1);
         if (rd_idx_ff == LAST_IDX) state_in = dfsp_pkg::ST_SYNC1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dfsp_pkg::ST_SYNC1;
         kind_ff        <= dfsp_pkg::KIND_SENSOR;
         field_pos_ff   <= '0;
         stamp_count_ff <= '0;
         counter_ff     <= '0;
         rd_idx_ff      <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kind_ff        <= kind_in;
         field_pos_ff   <= field_pos_in;
         stamp_count_ff <= stamp_count_in;
         counter_ff     <= counter_in;
         rd_idx_ff      <= rd_idx_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_acc && state_ff == dfsp_pkg::ST_HDR1) header_first_ff <= b;
      if (req_acc && state_ff == dfsp_pkg::ST_SENS) payload_ff[field_pos_ff] <= b;
      if (req_acc && state_ff == dfsp_pkg::ST_DATA) payload_ff[field_pos_ff] <= b;
   end

   // stamp memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_acc && state_ff == dfsp_pkg::ST_STAMP) stamp_mem[stamp_count_ff] <= b;
      if (rd_issue) rd_data_ff <= stamp_mem[rd_idx_ff];
   end

   a_land_slot_free: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !rsp_valid_ff)
      else $error("memory data landed while output register busy");

   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfsp_pkg::ST_DRAIN) |-> !req_acc)
      else $error("byte accepted during drain");

   a_last_stamp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last && rsp_ff.packet_kind == dfsp_pkg::KIND_STAMP)
         |-> (rsp_ff.stamp_char == 8'h00))
      else $error("final timestamp byte not forced to zero");

   a_count_on_lf: assert property (@(posedge clock) disable iff (reset)
      (counter_ff != counter_in) |-> lf_ok)
      else $error("packet count moved without a completed packet");

   a_drain_from_lf: assert property (@(posedge clock) disable iff (reset)
      (lf_ok && kind_ff == dfsp_pkg::KIND_STAMP) |=> (state_ff == dfsp_pkg::ST_DRAIN))
      else $error("stamp packet completed without drain");

endmodule
